>>> rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants of the delivery rate sampler
// Event codes, payload structs and the fixed widths of the rate divider.
// ----------------------------------------------------------------------------
package drs_pkg;

	// event codes
	localparam logic [2:0] MODE_SENT    = 3'd0;
	localparam logic [2:0] MODE_CACK    = 3'd1;
	localparam logic [2:0] MODE_SACK    = 3'd2;
	localparam logic [2:0] MODE_LOST    = 3'd3;
	localparam logic [2:0] MODE_TIMEOUT = 3'd4;

	// fixed widths
	localparam int BYTES_W    = 48;
	localparam int FIELD_T_W  = 48;
	localparam int RATE_W     = 40;
	localparam int RATE_SHIFT = 11;  // times 8 for bits, 8 fractional bits
	localparam int DVD_W      = 1 + BYTES_W + RATE_SHIFT;
	localparam int DIV_STEPS  = DVD_W / 2;
	localparam int CNT_W      = $clog2(DIV_STEPS + 1);

	localparam logic [7:0] HDR_RESET = 8'd52;

	typedef struct packed {
		logic [2:0]  mode;
		logic [47:0] now_us;
		logic [31:0] seq;
		logic [15:0] payload_len;
		logic [47:0] pkt_delivered;
		logic [47:0] pkt_delivered_ts;
		logic [47:0] pkt_sent_ts;
		logic [47:0] pkt_first_sent_ts;
	} in_item_t;

	typedef struct packed {
		logic [47:0]        snap_delivered;
		logic [47:0]        snap_delivered_ts;
		logic [47:0]        snap_sent_ts;
		logic [47:0]        snap_first_sent_ts;
		logic               accepted;
		logic               rate_valid;
		logic [39:0]        rate_mbps;
		logic signed [31:0] in_flight;
		logic               packet_lost;
	} out_item_t;

	// work handed from the front to the back, apart from the interval
	typedef struct packed {
		logic [47:0]        snap_delivered;
		logic [47:0]        snap_delivered_ts;
		logic [47:0]        snap_sent_ts;
		logic [47:0]        snap_first_sent_ts;
		logic               accepted;
		logic               need_div;
		logic [31:0]        in_flight;
		logic               packet_lost;
		logic [BYTES_W-1:0] bytes;
	} job_t;

endpackage

>>> rtl/drs_front.sv
// ----------------------------------------------------------------------------
// drs_front: event classification and counter update
// Takes one event per transfer, updates sequence, flight and delivery state,
// and hands a job with the byte count and interval for the rate to the queue.
// ----------------------------------------------------------------------------
module drs_front
	import drs_pkg::*;
#(
	parameter int TIME_BITS = 48,
	parameter int SEQ_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 push_valid,
	input  logic                 push_ready,
	output job_t                 push_job,
	output logic [TIME_BITS-1:0] push_interval
);

	logic [7:0]           hdr_q;
	logic [SEQ_BITS-1:0]  ha_q, ha_d, hs_q, hs_d;
	logic [31:0]          fc_q, fc_d;
	logic [BYTES_W-1:0]   td_q, td_d;
	logic [TIME_BITS-1:0] tdt_q, tdt_d, lfs_q, lfs_d;
	logic                 lost_q, lost_d;

	logic [63:0]          now64, pdts64, psent64, tdt64, lfs64, nowt64;
	logic [TIME_BITS-1:0] now_v, pdts_v, psent_v;
	logic [31:0]          seq32;
	logic [SEQ_BITS-1:0]  seq_v;
	logic [16:0]          len_hdr, add_v;
	logic                 take;

	// input fields at internal widths
	assign now64   = 64'(in_item.now_us);
	assign pdts64  = 64'(in_item.pkt_delivered_ts);
	assign psent64 = 64'(in_item.pkt_sent_ts);
	assign now_v   = now64[TIME_BITS-1:0];
	assign pdts_v  = pdts64[TIME_BITS-1:0];
	assign psent_v = psent64[TIME_BITS-1:0];
	assign nowt64  = 64'(now_v);
	assign seq32   = in_item.seq;
	assign seq_v   = seq32[SEQ_BITS-1:0];
	assign tdt64   = 64'(tdt_q);
	assign lfs64   = 64'(lfs_q);
	assign len_hdr = 17'(in_item.payload_len) + 17'(hdr_q);

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign take       = in_valid && push_ready;

	// next state and job contents
	always_comb begin
		ha_d          = ha_q;
		hs_d          = hs_q;
		fc_d          = fc_q;
		td_d          = td_q;
		tdt_d         = tdt_q;
		lfs_d         = lfs_q;
		lost_d        = lost_q;
		add_v         = '0;
		push_job      = '0;
		push_interval = '0;
		case (in_item.mode)
			MODE_SENT: begin
				if (seq_v > hs_q) begin
					hs_d = seq_v;
					fc_d = fc_q + 32'd1;
				end
				push_job.snap_delivered     = td_q;
				push_job.snap_delivered_ts  = tdt64[47:0];
				push_job.snap_sent_ts       = nowt64[47:0];
				push_job.snap_first_sent_ts = lfs64[47:0];
			end
			MODE_CACK, MODE_SACK, MODE_LOST: begin
				if ((pdts_v != '0) && (seq_v >= ha_q)) begin
					push_job.accepted = 1'b1;
					case (in_item.mode)
						MODE_CACK: begin
							ha_d   = seq_v + SEQ_BITS'(1);
							fc_d   = 32'(hs_q) - 32'(ha_d) + 32'd1;
							lost_d = 1'b0;
							add_v  = len_hdr;
						end
						MODE_SACK: begin
							fc_d   = fc_q - 32'd1;
							lost_d = 1'b1;
							add_v  = len_hdr;
						end
						default: begin
							lost_d = 1'b1;
						end
					endcase
					td_d  = td_q + BYTES_W'(add_v);
					tdt_d = now_v;
					lfs_d = psent_v;
					push_job.need_div = now_v > pdts_v;
					push_interval     = now_v - pdts_v;
					push_job.bytes    = (td_d >= in_item.pkt_delivered) ?
						td_d - in_item.pkt_delivered : '0;
				end
			end
			MODE_TIMEOUT: begin
				ha_d   = seq_v;
				lost_d = 1'b0;
				td_d   = '0;
				tdt_d  = now_v;
				lfs_d  = now_v;
			end
			default: begin
			end
		endcase
		push_job.in_flight   = fc_d;
		push_job.packet_lost = lost_d;
	end

	// header overhead register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= HDR_RESET;
		end else if (cfg_we) begin
			hdr_q <= cfg_wdata;
		end
	end

	// sampler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ha_q   <= '0;
			hs_q   <= '0;
			fc_q   <= '0;
			td_q   <= '0;
			tdt_q  <= '0;
			lfs_q  <= '0;
			lost_q <= 1'b0;
		end else if (take) begin
			ha_q   <= ha_d;
			hs_q   <= hs_d;
			fc_q   <= fc_d;
			td_q   <= td_d;
			tdt_q  <= tdt_d;
			lfs_q  <= lfs_d;
			lost_q <= lost_d;
		end
	end

endmodule

>>> rtl/drs_queue.sv
// ----------------------------------------------------------------------------
// drs_queue: two-entry job queue
// Decouples the front update from the rate divider so each side stalls alone.
// ----------------------------------------------------------------------------
module drs_queue
	import drs_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] mem_q [0:1];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/drs_back.sv
// ----------------------------------------------------------------------------
// drs_back: rate divider and result register
// Divides bytes * 2048 by the ack interval two quotient bits a cycle,
// saturates to 40 bits, keeps the latest rate and drives the result.
// ----------------------------------------------------------------------------
module drs_back
	import drs_pkg::*;
#(
	parameter int TIME_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  job_t                 pop_job,
	input  logic [TIME_BITS-1:0] pop_interval,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item
);

	localparam logic BK_IDLE = 1'b0;
	localparam logic BK_DIV  = 1'b1;

	logic                 state_q;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic [RATE_W-1:0]    last_rate_q;

	job_t                 job_q;
	logic [TIME_BITS-1:0] den_q;
	logic [TIME_BITS:0]   rem_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [RATE_W-1:0]    quo_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [TIME_BITS:0]   r  [0:2];
	logic [TIME_BITS:0]   rs [0:1];
	logic [DVD_W-1:0]     dv [0:2];
	logic [RATE_W-1:0]    qv [0:2];
	logic                 ov [0:2];
	logic [RATE_W-1:0]    sat_rate;
	logic                 out_free, pop, finish;

	assign out_free  = !out_valid_q || out_ready;
	assign pop_ready = (state_q == BK_IDLE) && (pop_job.need_div || out_free);
	assign pop       = pop_valid && pop_ready;
	assign finish    = (state_q == BK_DIV) && (cnt_q == '0) && out_free;
	assign sat_rate  = ovf_q ? '1 : quo_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// two restoring division steps
	always_comb begin
		r[0]  = rem_q;
		dv[0] = dvd_q;
		qv[0] = quo_q;
		ov[0] = ovf_q;
		for (int i = 0; i < 2; i++) begin
			rs[i]    = {r[i][TIME_BITS-1:0], dv[i][DVD_W-1]};
			ov[i+1]  = ov[i] | qv[i][RATE_W-1];
			dv[i+1]  = {dv[i][DVD_W-2:0], 1'b0};
			if (rs[i] >= {1'b0, den_q}) begin
				r[i+1]  = rs[i] - {1'b0, den_q};
				qv[i+1] = {qv[i][RATE_W-2:0], 1'b1};
			end else begin
				r[i+1]  = rs[i];
				qv[i+1] = {qv[i][RATE_W-2:0], 1'b0};
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (pop && pop_job.need_div) begin
			job_q <= pop_job;
			den_q <= pop_interval;
			rem_q <= '0;
			dvd_q <= {1'b0, pop_job.bytes, {RATE_SHIFT{1'b0}}};
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if ((state_q == BK_DIV) && (cnt_q != '0)) begin
			rem_q <= r[2];
			dvd_q <= dv[2];
			quo_q <= qv[2];
			ovf_q <= ov[2];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && !pop_job.need_div) begin
			out_q.snap_delivered     <= pop_job.snap_delivered;
			out_q.snap_delivered_ts  <= pop_job.snap_delivered_ts;
			out_q.snap_sent_ts       <= pop_job.snap_sent_ts;
			out_q.snap_first_sent_ts <= pop_job.snap_first_sent_ts;
			out_q.accepted           <= pop_job.accepted;
			out_q.rate_valid         <= 1'b0;
			out_q.rate_mbps          <= last_rate_q;
			out_q.in_flight          <= pop_job.in_flight;
			out_q.packet_lost        <= pop_job.packet_lost;
		end else if (finish) begin
			out_q.snap_delivered     <= job_q.snap_delivered;
			out_q.snap_delivered_ts  <= job_q.snap_delivered_ts;
			out_q.snap_sent_ts       <= job_q.snap_sent_ts;
			out_q.snap_first_sent_ts <= job_q.snap_first_sent_ts;
			out_q.accepted           <= job_q.accepted;
			out_q.rate_valid         <= 1'b1;
			out_q.rate_mbps          <= sat_rate;
			out_q.in_flight          <= job_q.in_flight;
			out_q.packet_lost        <= job_q.packet_lost;
		end
	end

	// control, step count and latest rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			last_rate_q <= '0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (pop && pop_job.need_div) begin
						state_q <= BK_DIV;
						cnt_q   <= CNT_W'(DIV_STEPS);
					end
				end
				BK_DIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else if (out_free) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
			if (finish) begin
				last_rate_q <= sat_rate;
			end
			if ((pop && !pop_job.need_div) || finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/delivery_rate_sampler.sv
// ----------------------------------------------------------------------------
// delivery_rate_sampler: per-packet delivery rate sampler
// Send, ack, selective ack, loss and timeout events in; one result each.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid / in_ready / in_item) carries one event per transfer;
//   out channel (out_valid / out_ready / out_item) returns exactly one result
//   per event, in event order. cfg_we / cfg_wdata write the header overhead.
//   After reset a timeout event must seed the timestamps before acks count.
// Flow:
//   the front updates all counters in the cycle of the transfer and queues a
//   job; the back registers the result of an event without a rate sample
//   straight from the queue, and runs the rate divider first for an event
//   that takes one. The divider retires two quotient bits a cycle and holds
//   the back while it works; other events flow at one per cycle unless the
//   output stalls. The two-entry queue lets the front take two events meanwhile.
// Reset:
//   asynchronous, active low; clears all counters, the latest rate and the
//   queue, and sets the header overhead to 52 bytes.
// Stall:
//   a held result waits in the output register; the back stops popping once
//   it needs the output, the queue fills and in_ready drops, with no event lost.
// ----------------------------------------------------------------------------
module delivery_rate_sampler
	import drs_pkg::*;
#(
	parameter int TIME_BITS = 48,
	parameter int SEQ_BITS  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int QW = $bits(job_t) + TIME_BITS;

	logic                 push_valid, push_ready, pop_valid, pop_ready;
	job_t                 push_job, pop_job;
	logic [TIME_BITS-1:0] push_interval, pop_interval;
	logic [QW-1:0]        pop_data;

	// event front end
	drs_front #(
		.TIME_BITS (TIME_BITS),
		.SEQ_BITS  (SEQ_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_item),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_job      (push_job),
		.push_interval (push_interval)
	);

	// job queue
	drs_queue #(
		.W (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_job, push_interval}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_job      = pop_data[QW-1:TIME_BITS];
	assign pop_interval = pop_data[TIME_BITS-1:0];

	// rate back end
	drs_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_job      (pop_job),
		.pop_interval (pop_interval),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item)
	);

`ifndef ASSERT_OFF
	// an accepted event is queued for the back end
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> pop_valid)
		else $error("accepted event missing from job queue");

	// a rate sample only comes from a processed ack or loss event
	a_rate_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.rate_valid) |-> out_item.accepted)
		else $error("rate sample without processed ack");

	// processed ack results carry no send snapshot
	a_ack_no_snap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.accepted) |->
		((out_item.snap_delivered == '0) && (out_item.snap_sent_ts == '0)))
		else $error("snapshot on ack result");
`endif

endmodule
